// File: hdl/leib_pkg.sv
// ----------------------------------------------------------------------------
// leib_pkg
// Shared constants, types and position helpers for the line edit input buffer.
// ----------------------------------------------------------------------------
package leib_pkg;

	localparam int BUF_DEPTH = 128;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int POS_W     = $clog2(2 * BUF_DEPTH);

	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(2 * BUF_DEPTH - 1);
	localparam logic [POS_W-1:0] POS_DEPTH = POS_W'(BUF_DEPTH);

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_EMPTY = 2'd2
	} out_kind_t;

	typedef enum logic [1:0] {
		RES_SINGLE  = 2'd0,
		RES_NEWLINE = 2'd1,
		RES_ERASE   = 2'd2
	} res_mode_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic capture;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic noop;
		logic read_data;
		logic res_last;
	} sts_t;

	function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
		return (p == POS_LAST) ? '0 : p + POS_W'(1);
	endfunction

	function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] p);
		return (p == '0) ? POS_LAST : p - POS_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] pos_slot(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] s;
		s = (p >= POS_DEPTH) ? p - POS_DEPTH : p;
		return s[ADDR_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] fill_level(input logic [POS_W-1:0] e,
			input logic [POS_W-1:0] r);
		logic [POS_W:0] t;
		t = {1'b0, e} + (POS_W+1)'(2 * BUF_DEPTH) - {1'b0, r};
		return (e >= r) ? e - r : t[POS_W-1:0];
	endfunction

endpackage

// File: hdl/leib_req_if.sv
// ----------------------------------------------------------------------------
// leib_req_if
// Request channel: received character or read request, valid/ready.
// ----------------------------------------------------------------------------
interface leib_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// File: hdl/leib_res_if.sv
// ----------------------------------------------------------------------------
// leib_res_if
// Result channel: echo bytes, read data or empty reports, valid/ready.
// ----------------------------------------------------------------------------
interface leib_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       end_of_line;
	logic       last;

	modport source (output valid, output out_kind, output out_byte,
		output end_of_line, output last, input ready);
	modport sink   (input valid, input out_kind, input out_byte,
		input end_of_line, input last, output ready);
endinterface

// File: hdl/leib_ram.sv
// ----------------------------------------------------------------------------
// leib_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module leib_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/leib_ctrl.sv
// ----------------------------------------------------------------------------
// leib_ctrl
// Sequencer: accept a request, evaluate it, wait for store data, emit results.
// ----------------------------------------------------------------------------
module leib_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output leib_pkg::cmd_t cmd,
	input  leib_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EVAL   = 4'b0010,
		ST_RDWAIT = 4'b0100,
		ST_OUT    = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				priority if (sts.noop) state_d = ST_IDLE;
				else if (sts.read_data) state_d = ST_RDWAIT;
				else state_d = ST_OUT;
			end
			ST_RDWAIT: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// stay until the final result of the request is taken
				if (out_ready && sts.res_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign cmd.load    = (state_q == ST_IDLE) && in_valid;
	assign cmd.eval    = (state_q == ST_EVAL);
	assign cmd.capture = (state_q == ST_RDWAIT);
	assign cmd.step    = (state_q == ST_OUT) && out_ready;

endmodule

// File: hdl/leib_dp.sv
// ----------------------------------------------------------------------------
// leib_dp
// Datapath: ring positions, line store, request decode and result register.
// ----------------------------------------------------------------------------
module leib_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  leib_pkg::cmd_t cmd,
	output leib_pkg::sts_t sts,
	input  logic           req_type,
	input  logic [7:0]     rx_byte,
	output logic [1:0]     out_kind,
	output logic [7:0]     out_byte,
	output logic           end_of_line,
	output logic           last
);

	logic                       req_q;
	logic [7:0]                 byte_q;
	logic [leib_pkg::POS_W-1:0] read_pos_q, commit_pos_q, edit_pos_q;
	leib_pkg::res_mode_t        res_mode_q;
	logic [1:0]                 res_idx_q;
	leib_pkg::out_kind_t        res_kind_q;
	logic [7:0]                 res_byte_q;
	logic                       res_eol_q;

	logic                       is_read, is_lf, is_erase, room, empty, do_store;
	logic [leib_pkg::POS_W-1:0] edit_inc;
	logic                       ram_re;
	logic [7:0]                 ram_rdata;

	assign is_read  = (req_q == leib_pkg::REQ_READ);
	assign is_lf    = (byte_q == leib_pkg::CH_LF);
	assign is_erase = (byte_q == leib_pkg::CH_BS) || (byte_q == leib_pkg::CH_DEL);
	assign room     = leib_pkg::fill_level(edit_pos_q, read_pos_q) < leib_pkg::POS_DEPTH;
	assign empty    = (read_pos_q == commit_pos_q);
	assign edit_inc = leib_pkg::pos_inc(edit_pos_q);

	// line feed is stored when there is room; nul bytes are only echoed
	assign do_store = !is_read && room && !is_erase && (is_lf || byte_q != leib_pkg::CH_NUL);
	assign ram_re   = cmd.eval && is_read && !empty;

	leib_ram #(
		.WIDTH(8),
		.DEPTH(leib_pkg::BUF_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.eval && do_store),
		.waddr(leib_pkg::pos_slot(edit_pos_q)),
		.wdata(byte_q),
		.re   (ram_re),
		.raddr(leib_pkg::pos_slot(read_pos_q)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_pos_q   <= '0;
			commit_pos_q <= '0;
			edit_pos_q   <= '0;
			res_idx_q    <= '0;
		end else begin
			if (cmd.eval) begin
				res_idx_q <= '0;
				priority if (is_read) begin
					if (!empty) read_pos_q <= leib_pkg::pos_inc(read_pos_q);
				end else if (is_lf) begin
					edit_pos_q   <= room ? edit_inc : edit_pos_q;
					commit_pos_q <= room ? edit_inc : edit_pos_q;
				end else if (is_erase) begin
					if (edit_pos_q != commit_pos_q) begin
						edit_pos_q <= leib_pkg::pos_dec(edit_pos_q);
					end
				end else begin
					if (do_store) edit_pos_q <= edit_inc;
				end
			end else if (cmd.step) begin
				res_idx_q <= res_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			byte_q <= (rx_byte == leib_pkg::CH_CR) ? leib_pkg::CH_LF : rx_byte;
		end
		if (cmd.eval) begin
			res_eol_q <= 1'b0;
			priority if (is_read) begin
				res_mode_q <= leib_pkg::RES_SINGLE;
				res_kind_q <= leib_pkg::KIND_EMPTY;
				res_byte_q <= leib_pkg::CH_NUL;
			end else if (is_lf) begin
				res_mode_q <= leib_pkg::RES_NEWLINE;
				res_kind_q <= leib_pkg::KIND_ECHO;
				res_byte_q <= byte_q;
			end else if (is_erase) begin
				res_mode_q <= leib_pkg::RES_ERASE;
				res_kind_q <= leib_pkg::KIND_ECHO;
				res_byte_q <= byte_q;
			end else begin
				res_mode_q <= leib_pkg::RES_SINGLE;
				res_kind_q <= leib_pkg::KIND_ECHO;
				res_byte_q <= byte_q;
			end
		end
		if (cmd.capture) begin
			res_kind_q <= leib_pkg::KIND_DATA;
			res_byte_q <= ram_rdata;
			res_eol_q  <= (ram_rdata == leib_pkg::CH_LF);
		end
	end

	always_comb begin
		out_kind    = res_kind_q;
		out_byte    = res_byte_q;
		end_of_line = res_eol_q;
		last        = 1'b1;
		unique case (res_mode_q)
			leib_pkg::RES_SINGLE: begin
				last = 1'b1;
			end
			leib_pkg::RES_NEWLINE: begin
				out_byte = (res_idx_q == 2'd0) ? leib_pkg::CH_CR : leib_pkg::CH_LF;
				last     = (res_idx_q == 2'd1);
			end
			leib_pkg::RES_ERASE: begin
				out_byte = (res_idx_q == 2'd1) ? leib_pkg::CH_SP : leib_pkg::CH_BS;
				last     = (res_idx_q == 2'd2);
			end
			default: begin
				last = 1'b1;
			end
		endcase
	end

	assign sts.noop      = !is_read && is_erase && (edit_pos_q == commit_pos_q);
	assign sts.read_data = is_read && !empty;
	assign sts.res_last  = last;

endmodule

// File: hdl/line_edit_input_buffer_unit.sv
// ----------------------------------------------------------------------------
// line_edit_input_buffer_unit
// Console line editing ring buffer with echo and non-blocking byte reads.
// ----------------------------------------------------------------------------
// One request is handled at a time. A received character is accepted and
// evaluated, then each of its echo results is offered in turn: one for a plain
// byte, two for a line feed (CR, LF) and three for an erase (BS, SP, BS); an
// erase with nothing to remove returns to idle with no result. A read that
// returns a byte passes through an extra wait state, set by the registered read
// port of the line store; an empty read goes straight to its result. The next
// request is accepted once the last result has been taken. The line store has
// no reset and needs no clearing pass.
module line_edit_input_buffer_unit (
	input  logic      clk,
	input  logic      arst_n,
	leib_req_if.sink  req,
	leib_res_if.source res
);

	leib_pkg::cmd_t cmd;
	leib_pkg::sts_t sts;

	leib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	leib_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req.req_type),
		.rx_byte    (req.rx_byte),
		.out_kind   (res.out_kind),
		.out_byte   (res.out_byte),
		.end_of_line(res.end_of_line),
		.last       (res.last)
	);

endmodule

// File: tb/line_edit_input_buffer_unit_tb.sv
// ----------------------------------------------------------------------------
// line_edit_input_buffer_unit_tb
// Drives received characters and read requests into the line edit buffer,
// predicts the echo and read results from a shadow ring, and checks every
// result field by field. Both channels idle at random, and the receiver
// holds off for one long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_edit_input_buffer_unit_tb;

	typedef struct packed {
		logic       rtype;
		logic [7:0] ch;
	} console_req_t;

	typedef struct packed {
		leib_pkg::out_kind_t kind;
		logic [7:0]          data;
		logic                eol;
		logic                last;
	} console_out_t;

	logic clk;
	logic arst_n;

	leib_req_if req_ch ();
	leib_res_if res_ch ();

	line_edit_input_buffer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	console_req_t pending_reqs[$];
	console_out_t want_out[$];

	// shadow copy of the ring and its three positions
	logic [7:0]                 ring [leib_pkg::BUF_DEPTH];
	logic [leib_pkg::POS_W-1:0] rd_ptr;
	logic [leib_pkg::POS_W-1:0] cm_ptr;
	logic [leib_pkg::POS_W-1:0] ed_ptr;

	int n_items;
	int sent_cnt;
	int seen_cnt;
	int errors;
	int send_gap;
	int recv_gap;
	int hold_left;
	int cyc;
	logic hold_done;
	logic calm;
	console_req_t nxt;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [leib_pkg::POS_W-1:0] step_pos(
			input logic [leib_pkg::POS_W-1:0] p, input bit up);
		int m;
		m = 2 * leib_pkg::BUF_DEPTH;
		return leib_pkg::POS_W'((int'(p) + (up ? 1 : m - 1)) % m);
	endfunction

	function automatic logic [leib_pkg::ADDR_W-1:0] ring_slot(
			input logic [leib_pkg::POS_W-1:0] p);
		return leib_pkg::ADDR_W'(int'(p) % leib_pkg::BUF_DEPTH);
	endfunction

	function automatic int ring_used();
		int m;
		m = 2 * leib_pkg::BUF_DEPTH;
		return (int'(ed_ptr) + m - int'(rd_ptr)) % m;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 19) < 16)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (b == leib_pkg::CH_CR || b == leib_pkg::CH_LF || b == leib_pkg::CH_BS ||
				b == leib_pkg::CH_DEL)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic push_out(input leib_pkg::out_kind_t k, input logic [7:0] d,
			input logic e, input logic l);
		console_out_t r;
		r.kind = k;
		r.data = d;
		r.eol  = e;
		r.last = l;
		want_out.push_back(r);
	endtask

	task automatic edit_and_echo(input logic rtype, input logic [7:0] ch);
		logic [7:0] c;
		logic [7:0] b;
		c = ch;
		if (rtype == leib_pkg::REQ_READ) begin
			if (rd_ptr == cm_ptr) begin
				push_out(leib_pkg::KIND_EMPTY, leib_pkg::CH_NUL, 1'b0, 1'b1);
			end else begin
				b = ring[ring_slot(rd_ptr)];
				rd_ptr = step_pos(rd_ptr, 1'b1);
				push_out(leib_pkg::KIND_DATA, b, b == leib_pkg::CH_LF, 1'b1);
			end
			return;
		end
		if (c == leib_pkg::CH_CR)
			c = leib_pkg::CH_LF;
		if (c == leib_pkg::CH_LF) begin
			// a full ring drops the line feed but still commits the line
			if (ring_used() < leib_pkg::BUF_DEPTH) begin
				ring[ring_slot(ed_ptr)] = c;
				ed_ptr = step_pos(ed_ptr, 1'b1);
			end
			cm_ptr = ed_ptr;
			push_out(leib_pkg::KIND_ECHO, leib_pkg::CH_CR, 1'b0, 1'b0);
			push_out(leib_pkg::KIND_ECHO, leib_pkg::CH_LF, 1'b0, 1'b1);
		end else if (c == leib_pkg::CH_BS || c == leib_pkg::CH_DEL) begin
			if (ed_ptr != cm_ptr) begin
				ed_ptr = step_pos(ed_ptr, 1'b0);
				push_out(leib_pkg::KIND_ECHO, leib_pkg::CH_BS, 1'b0, 1'b0);
				push_out(leib_pkg::KIND_ECHO, leib_pkg::CH_SP, 1'b0, 1'b0);
				push_out(leib_pkg::KIND_ECHO, leib_pkg::CH_BS, 1'b0, 1'b1);
			end
		end else begin
			if (c != leib_pkg::CH_NUL && ring_used() < leib_pkg::BUF_DEPTH) begin
				ring[ring_slot(ed_ptr)] = c;
				ed_ptr = step_pos(ed_ptr, 1'b1);
			end
			push_out(leib_pkg::KIND_ECHO, c, 1'b0, 1'b1);
		end
	endtask

	task automatic queue_char(input logic [7:0] c);
		console_req_t r;
		r.rtype = leib_pkg::REQ_CHAR;
		r.ch    = c;
		pending_reqs.push_back(r);
		n_items++;
	endtask

	task automatic queue_read(input int n);
		console_req_t r;
		for (int i = 0; i < n; i++) begin
			r.rtype = leib_pkg::REQ_READ;
			r.ch    = 8'($urandom_range(0, 255));
			pending_reqs.push_back(r);
			n_items++;
		end
	endtask

	// types past a full ring, commits with no room left, tries to erase past the
	// committed line, then commits again and drains it
	task automatic overfill_and_drain();
		for (int i = 0; i < leib_pkg::BUF_DEPTH + 10; i++)
			queue_char(plain_byte());
		queue_char(leib_pkg::CH_LF);
		queue_char(leib_pkg::CH_BS);
		queue_char(leib_pkg::CH_DEL);
		queue_char(plain_byte());
		queue_char(leib_pkg::CH_LF);
		queue_read(leib_pkg::BUF_DEPTH + 3);
	endtask

	// cycle counter and the long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc       <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			cyc <= cyc + 1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && seen_cnt >= 60) begin
				hold_left <= 300;
				hold_done <= 1'b1;
			end
		end
	end

	assign calm = (cyc % 3000) < 500;

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.req_type <= leib_pkg::REQ_CHAR;
			req_ch.rx_byte  <= 8'h00;
			send_gap        <= 0;
			sent_cnt        <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				edit_and_echo(req_ch.req_type, req_ch.rx_byte);
				sent_cnt <= sent_cnt + 1;
			end
			if (req_ch.valid && !req_ch.ready) begin
				// offered request stays on the bus
			end else if (send_gap != 0) begin
				send_gap     <= send_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (req_ch.valid && !calm && $urandom_range(0, 4) == 0) begin
				send_gap     <= gap_len() - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				nxt = pending_reqs.pop_front();
				req_ch.valid    <= 1'b1;
				req_ch.req_type <= nxt.rtype;
				req_ch.rx_byte  <= nxt.ch;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		console_out_t exp_r;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_gap     <= 0;
			seen_cnt     <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				seen_cnt <= seen_cnt + 1;
				if (want_out.size() == 0) begin
					if (errors < 10)
						$display("unexpected result kind=%0d byte=%02h eol=%b last=%b",
							res_ch.out_kind, res_ch.out_byte, res_ch.end_of_line,
							res_ch.last);
					errors++;
				end else begin
					exp_r = want_out.pop_front();
					if (res_ch.out_kind !== exp_r.kind || res_ch.out_byte !== exp_r.data ||
							res_ch.end_of_line !== exp_r.eol || res_ch.last !== exp_r.last) begin
						if (errors < 10)
							$display({"mismatch exp kind=%0d byte=%02h eol=%b last=%b,",
								" got kind=%0d byte=%02h eol=%b last=%b"},
								exp_r.kind, exp_r.data, exp_r.eol, exp_r.last,
								res_ch.out_kind, res_ch.out_byte, res_ch.end_of_line,
								res_ch.last);
						errors++;
					end
				end
			end
			if (recv_gap != 0) begin
				recv_gap     <= recv_gap - 1;
				res_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
			end else if (calm || $urandom_range(0, 3) != 0) begin
				res_ch.ready <= 1'b1;
			end else begin
				recv_gap     <= gap_len() - 1;
				res_ch.ready <= 1'b0;
			end
		end
	end

	initial begin
		int sel;
		int n;
		bit burst1;
		bit burst2;
		n_items = 0;
		errors  = 0;
		rd_ptr  = '0;
		cm_ptr  = '0;
		ed_ptr  = '0;
		burst1  = 1'b0;
		burst2  = 1'b0;

		// directed: empty read, erase with nothing to erase, extremes of the byte
		queue_read(1);
		queue_char(leib_pkg::CH_BS);
		queue_char(leib_pkg::CH_DEL);
		queue_char(8'h61);
		queue_char(leib_pkg::CH_NUL);
		queue_char(8'hFF);
		queue_char(8'h01);
		queue_char(8'h80);
		queue_char(leib_pkg::CH_BS);
		queue_char(leib_pkg::CH_DEL);
		queue_char(leib_pkg::CH_CR);
		queue_read(4);
		queue_char(leib_pkg::CH_BS);
		queue_char(8'h78);
		queue_char(leib_pkg::CH_LF);
		queue_read(3);

		while (n_items < 520) begin
			if (!burst1 && n_items > 100) begin
				overfill_and_drain();
				burst1 = 1'b1;
			end else if (!burst2 && n_items > 300) begin
				overfill_and_drain();
				burst2 = 1'b1;
			end
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				n = $urandom_range(0, 12);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 7) == 0)
						queue_char($urandom_range(0, 1) ? leib_pkg::CH_BS : leib_pkg::CH_DEL);
					else
						queue_char(plain_byte());
				end
				queue_char($urandom_range(0, 1) ? leib_pkg::CH_CR : leib_pkg::CH_LF);
				queue_read($urandom_range(0, n + 3));
			end else if (sel < 80) begin
				queue_read($urandom_range(1, 6));
			end else begin
				// noise: any request type with any byte
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 1))
						queue_read(1);
					else
						queue_char(8'($urandom_range(0, 255)));
				end
			end
		end

		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (sent_cnt != n_items);
		do @(posedge clk); while (want_out.size() != 0);
		repeat (40) @(posedge clk);

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
